// ===== hdl/tlbpt_pkg.sv =====
// ----------------------------------------------------------------------------
// tlbpt_pkg: shared types and constants of the TLB translate unit
// Sizes of the TLB and page table, entry types and the page reduction table.
// ----------------------------------------------------------------------------
package tlbpt_pkg;

  // Sizes
  localparam int TLB_ENTRIES = 16;
  localparam int PAGE_COUNT  = 256;
  localparam int PAGE_W      = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;

  // Field widths
  localparam int VPN_W   = 8;
  localparam int OFF_W   = 8;
  localparam int FRAME_W = 8;
  localparam int ADDR_W  = 16;
  localparam int CNT_W   = 16;
  localparam int VPN_NUM = 2 ** VPN_W;

  typedef logic [PAGE_W-1:0] page_idx_t;
  typedef logic [VPN_NUM-1:0][PAGE_W-1:0] page_lut_t;

  // One TLB entry as it moves down the cell chain
  typedef struct packed {
    logic               valid;
    logic [VPN_W-1:0]   page;
    logic [FRAME_W-1:0] frame;
  } tlbpt_entry_t;

  // Page-table write request
  typedef struct packed {
    logic               en;
    page_idx_t          page;
    logic [FRAME_W-1:0] frame;
  } tlbpt_pt_wr_t;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_LOOK
  } tlbpt_state_e;

  // Virtual page reduced modulo the page count, worked out at elaboration
  function automatic page_lut_t build_page_lut();
    page_lut_t lut;
    for (int i = 0; i < VPN_NUM; i++) begin
      lut[i] = PAGE_W'(i % PAGE_COUNT);
    end
    return lut;
  endfunction

  localparam page_lut_t PAGE_LUT = build_page_lut();

endpackage

// ===== hdl/tlbpt_if.sv =====
// ----------------------------------------------------------------------------
// tlbpt_if: request and response channels of the TLB translate unit
// Valid/ready streams; a word moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface tlbpt_req_if;
  logic                        valid;
  logic                        ready;
  logic [tlbpt_pkg::VPN_W-1:0] virtual_page;
  logic [tlbpt_pkg::OFF_W-1:0] page_offset;

  modport source (output valid, output virtual_page, output page_offset, input ready);
  modport sink   (input valid, input virtual_page, input page_offset, output ready);
endinterface

interface tlbpt_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [tlbpt_pkg::ADDR_W-1:0] physical_address;
  logic                         tlb_hit;
  logic                         page_fault;
  logic [tlbpt_pkg::CNT_W-1:0]  hit_count;
  logic [tlbpt_pkg::CNT_W-1:0]  miss_count;
  logic [tlbpt_pkg::CNT_W-1:0]  fault_count;

  modport source (
    output valid, output physical_address, output tlb_hit, output page_fault,
    output hit_count, output miss_count, output fault_count, input ready
  );
  modport sink (
    input valid, input physical_address, input tlb_hit, input page_fault,
    input hit_count, input miss_count, input fault_count, output ready
  );
endinterface

// ===== hdl/tlb_page_table_translate_unit.sv =====
// ----------------------------------------------------------------------------
// tlb_page_table_translate_unit: FIFO TLB with demand-paged page table
// Translates virtual page and offset into a physical address with counters.
// ----------------------------------------------------------------------------
//  channel  | dir | payload
//  ---------+-----+--------------------------------------------------------
//  req_i    | in  | virtual_page, page_offset
//  rsp_o    | out | physical_address, tlb_hit, page_fault, hit/miss/fault_count
//
//  The accept cycle issues the page-table read; in the ST_LOOK state that
//  follows, the TLB tag compare is done and the result register is loaded.
//  The TLB is a chain of cells; an insert shifts every entry one cell on.
//  Reset clears TLB and page-table valid bits, counters and frame pointer.
//  A word is held in the compare cycle while the result register is full
//  and not taken; a new request is accepted while a result waits.
// ----------------------------------------------------------------------------
module tlb_page_table_translate_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  tlbpt_req_if.sink    req_i,
  tlbpt_rsp_if.source  rsp_o
);

  localparam int N = tlbpt_pkg::TLB_ENTRIES;

  tlbpt_pkg::tlbpt_state_e state_q, state_d;

  logic [tlbpt_pkg::VPN_W-1:0]   page_q;
  logic [tlbpt_pkg::OFF_W-1:0]   off_q;
  logic [tlbpt_pkg::FRAME_W-1:0] next_frame_q, next_frame_d;
  logic [tlbpt_pkg::CNT_W-1:0]   hits_q, hits_d;
  logic [tlbpt_pkg::CNT_W-1:0]   misses_q, misses_d;
  logic [tlbpt_pkg::CNT_W-1:0]   faults_q, faults_d;

  logic                          out_valid_q, out_valid_d;
  logic [tlbpt_pkg::ADDR_W-1:0]  out_addr_q;
  logic                          out_hit_q, out_fault_q;

  logic                          accept;
  logic                          finish;
  logic                          hit;
  logic                          fault;
  logic [tlbpt_pkg::FRAME_W-1:0] hit_frame;
  logic [tlbpt_pkg::FRAME_W-1:0] frame;
  logic [tlbpt_pkg::FRAME_W-1:0] pt_frame;
  logic                          pt_valid;
  tlbpt_pkg::page_idx_t          req_page;
  tlbpt_pkg::tlbpt_pt_wr_t       pt_wr;

  tlbpt_pkg::tlbpt_entry_t       chain [N+1];
  logic [N-1:0]                  match;

  assign req_page = tlbpt_pkg::PAGE_LUT[req_i.virtual_page];
  assign accept   = req_i.valid && req_i.ready;

  // Control: next state, handshake and finish strobe
  always_comb begin
    state_d      = state_q;
    req_i.ready  = 1'b0;
    finish       = 1'b0;
    unique case (state_q)
      tlbpt_pkg::ST_IDLE: begin
        req_i.ready = 1'b1;
        if (req_i.valid) begin
          state_d = tlbpt_pkg::ST_LOOK;
        end
      end
      tlbpt_pkg::ST_LOOK: begin
        if (!out_valid_q || rsp_o.ready) begin
          finish  = 1'b1;
          state_d = tlbpt_pkg::ST_IDLE;
        end
      end
      default: state_d = tlbpt_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tlbpt_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Latch the request word
  always_ff @(posedge clk_i) begin
    if (accept) begin
      page_q <= tlbpt_pkg::VPN_W'(req_page);
      off_q  <= req_i.page_offset;
    end
  end

  // Page table
  tlbpt_page_table u_page_table (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_en_i    (accept),
    .rd_page_i  (req_page),
    .rd_frame_o (pt_frame),
    .rd_valid_o (pt_valid),
    .wr_i       (pt_wr)
  );

  // TLB cell chain; new entries enter at cell 0
  assign chain[0].valid = 1'b1;
  assign chain[0].page  = page_q;
  assign chain[0].frame = frame;

  for (genvar g = 0; g < N; g++) begin : g_cell
    tlbpt_cell u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .shift_i       (finish && !hit),
      .entry_i       (chain[g]),
      .lookup_page_i (page_q),
      .entry_o       (chain[g+1]),
      .match_o       (match[g])
    );
  end

  // Merge matches; a page sits in at most one cell
  always_comb begin
    hit_frame = '0;
    for (int i = 0; i < N; i++) begin
      hit_frame = hit_frame | ({tlbpt_pkg::FRAME_W{match[i]}} & chain[i+1].frame);
    end
  end

  assign hit   = |match;
  assign fault = !hit && !pt_valid;
  assign frame = hit ? hit_frame : (fault ? next_frame_q : pt_frame);

  assign pt_wr.en    = finish && fault;
  assign pt_wr.page  = tlbpt_pkg::page_idx_t'(page_q);
  assign pt_wr.frame = next_frame_q;

  // Counters and frame pointer
  always_comb begin
    next_frame_d = next_frame_q;
    hits_d       = hits_q;
    misses_d     = misses_q;
    faults_d     = faults_q;
    if (finish) begin
      if (hit) begin
        hits_d = hits_q + 1'b1;
      end else begin
        misses_d = misses_q + 1'b1;
      end
      if (fault) begin
        next_frame_d = next_frame_q + 1'b1;
        if (faults_q != {tlbpt_pkg::CNT_W{1'b1}}) begin
          faults_d = faults_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      next_frame_q <= '0;
      hits_q       <= '0;
      misses_q     <= '0;
      faults_q     <= '0;
    end else begin
      next_frame_q <= next_frame_d;
      hits_q       <= hits_d;
      misses_q     <= misses_d;
      faults_q     <= faults_d;
    end
  end

  // Result register
  always_comb begin
    out_valid_d = out_valid_q;
    if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (finish) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (finish) begin
      out_addr_q  <= {frame, off_q};
      out_hit_q   <= hit;
      out_fault_q <= fault;
    end
  end

  assign rsp_o.valid            = out_valid_q;
  assign rsp_o.physical_address = out_addr_q;
  assign rsp_o.tlb_hit          = out_hit_q;
  assign rsp_o.page_fault       = out_fault_q;
  assign rsp_o.hit_count        = hits_q;
  assign rsp_o.miss_count       = misses_q;
  assign rsp_o.fault_count      = faults_q;

endmodule

// ===== hdl/tlbpt_cell.sv =====
// ----------------------------------------------------------------------------
// tlbpt_cell: one TLB entry of the shifting FIFO chain
// Holds one entry, compares it against the lookup page and passes it on.
// ----------------------------------------------------------------------------
module tlbpt_cell (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              shift_i,
  input  tlbpt_pkg::tlbpt_entry_t           entry_i,
  input  logic [tlbpt_pkg::VPN_W-1:0]       lookup_page_i,
  output tlbpt_pkg::tlbpt_entry_t           entry_o,
  output logic                              match_o
);

  logic                          valid_q;
  logic [tlbpt_pkg::VPN_W-1:0]   page_q;
  logic [tlbpt_pkg::FRAME_W-1:0] frame_q;

  // Take the neighbor's entry on insert; the last cell's entry drops off
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (shift_i) begin
      valid_q <= entry_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      page_q  <= entry_i.page;
      frame_q <= entry_i.frame;
    end
  end

  assign entry_o.valid = valid_q;
  assign entry_o.page  = page_q;
  assign entry_o.frame = frame_q;

  // Tag compare
  assign match_o = valid_q && (page_q == lookup_page_i);

endmodule

// ===== hdl/tlbpt_page_table.sv =====
// ----------------------------------------------------------------------------
// tlbpt_page_table: frame memory and valid bits of the page table
// Registered read of frame and valid bit; one write port.
// ----------------------------------------------------------------------------
module tlbpt_page_table (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          rd_en_i,
  input  tlbpt_pkg::page_idx_t          rd_page_i,
  output logic [tlbpt_pkg::FRAME_W-1:0] rd_frame_o,
  output logic                          rd_valid_o,
  input  tlbpt_pkg::tlbpt_pt_wr_t       wr_i
);

  logic [tlbpt_pkg::FRAME_W-1:0] frame_mem [tlbpt_pkg::PAGE_COUNT];
  logic [tlbpt_pkg::PAGE_COUNT-1:0] valid_q;
  logic [tlbpt_pkg::FRAME_W-1:0] rd_frame_q;
  logic rd_valid_q;

  // Write and read the frame memory
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      frame_mem[wr_i.page] <= wr_i.frame;
    end
    if (rd_en_i) begin
      rd_frame_q <= frame_mem[rd_page_i];
    end
  end

  // Valid bits clear at reset, set on fault
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (wr_i.en) begin
        valid_q[wr_i.page] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_valid_q <= valid_q[rd_page_i];
      end
    end
  end

  assign rd_frame_o = rd_frame_q;
  assign rd_valid_o = rd_valid_q;

endmodule
